[src/lsmt_pkg.sv]
package lsmt_pkg;

	// Field widths of one word and one result.
	localparam int unsigned KEY_W = 31;
	localparam int unsigned ADDR_W = 48;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned SLOT_W = 5;

	// Default table depth.
	localparam int unsigned ENTRIES_DEF = 20;

	// One stored entry is {key, address, stamp}.
	localparam int unsigned WORD_W = KEY_W + ADDR_W + STAMP_W;
	localparam int unsigned STAMP_LSB = 0;
	localparam int unsigned ADDR_LSB = STAMP_W;
	localparam int unsigned KEY_LSB = STAMP_W + ADDR_W;

	// Command codes.
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic scan;
		logic commit;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_read;
	} dp_status_t;

endpackage

[src/lsmt_ram.sv]
module lsmt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/lsmt_ctrl.sv]
module lsmt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                command,
	input  lsmt_pkg::dp_status_t status,
	output lsmt_pkg::ctl_cmd_t  cmd,
	output logic                busy
);

	lsmt_pkg::state_t state_q;
	lsmt_pkg::state_t state_d;

	// Next state: a lookup scans all entries, a flush goes straight to commit.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lsmt_pkg::ST_IDLE: begin
				if (start) begin
					if (command == lsmt_pkg::CMD_FLUSH) begin
						state_d = lsmt_pkg::ST_COMMIT;
					end else begin
						state_d = lsmt_pkg::ST_SCAN;
					end
				end
			end
			lsmt_pkg::ST_SCAN: begin
				if (status.last_read) begin
					state_d = lsmt_pkg::ST_DRAIN;
				end
			end
			lsmt_pkg::ST_DRAIN: begin
				state_d = lsmt_pkg::ST_COMMIT;
			end
			lsmt_pkg::ST_COMMIT: begin
				state_d = lsmt_pkg::ST_IDLE;
			end
			default: begin
				state_d = lsmt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsmt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Command decode.
	assign busy = (state_q != lsmt_pkg::ST_IDLE);
	assign cmd.accept = (state_q == lsmt_pkg::ST_IDLE) && start;
	assign cmd.scan = (state_q == lsmt_pkg::ST_SCAN);
	assign cmd.commit = (state_q == lsmt_pkg::ST_COMMIT);

endmodule

[src/lsmt_datapath.sv]
module lsmt_datapath #(
	parameter int unsigned ENTRIES = lsmt_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lsmt_pkg::ctl_cmd_t            cmd,
	output lsmt_pkg::dp_status_t          status,
	input  logic                          command,
	input  logic [lsmt_pkg::KEY_W-1:0]    segment_key,
	input  logic [lsmt_pkg::ADDR_W-1:0]   fill_address,
	output logic                          done,
	output logic                          hit,
	output logic [lsmt_pkg::SLOT_W-1:0]   slot,
	output logic [lsmt_pkg::ADDR_W-1:0]   mapped_address,
	output logic                          evicted,
	output logic [lsmt_pkg::KEY_W-1:0]    evicted_key,
	output logic [lsmt_pkg::ADDR_W-1:0]   evicted_address
);

	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned KW = lsmt_pkg::KEY_W;
	localparam int unsigned AW = lsmt_pkg::ADDR_W;
	localparam int unsigned SW = lsmt_pkg::STAMP_W;
	localparam int unsigned WW = lsmt_pkg::WORD_W;

	// Latched request and the use counter.
	logic          flush_q;
	logic [KW-1:0] key_q;
	logic [AW-1:0] fill_q;
	logic [SW-1:0] cnt_q;

	// Valid bits and scan bookkeeping.
	logic [ENTRIES-1:0] valid_q;
	logic [IW-1:0]      idx_q;
	logic               chk_s1;
	logic [IW-1:0]      chk_idx_s1;
	logic               hit_q;
	logic [IW-1:0]      hit_idx_q;
	logic [AW-1:0]      hit_addr_q;
	logic               free_q;
	logic [IW-1:0]      free_idx_q;
	logic               have_min_q;
	logic [SW-1:0]      min_q;
	logic [IW-1:0]      min_idx_q;
	logic [KW-1:0]      min_key_q;
	logic [AW-1:0]      min_addr_q;

	// Entry memory.
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [WW-1:0] ram_wdata;
	logic [WW-1:0] ram_rdata;
	logic [KW-1:0] rd_key;
	logic [AW-1:0] rd_addr;
	logic [SW-1:0] rd_stamp;
	logic          rd_valid;

	// Commit decisions.
	logic          done_q;
	logic [IW-1:0] target;
	logic [AW-1:0] new_addr;
	logic          do_evict;

	lsmt_ram #(
		.WIDTH(WW),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign rd_key = ram_rdata[lsmt_pkg::KEY_LSB +: KW];
	assign rd_addr = ram_rdata[lsmt_pkg::ADDR_LSB +: AW];
	assign rd_stamp = ram_rdata[lsmt_pkg::STAMP_LSB +: SW];
	assign rd_valid = valid_q[chk_idx_s1];

	assign status.last_read = (idx_q == IW'(ENTRIES - 1));

	// Slot choice: hit first, then the lowest free slot, then the oldest entry.
	always_comb begin
		priority if (hit_q) begin
			target = hit_idx_q;
		end else if (free_q) begin
			target = free_idx_q;
		end else begin
			target = min_idx_q;
		end
	end

	assign new_addr = hit_q ? hit_addr_q : fill_q;
	assign do_evict = !hit_q && !free_q;

	assign ram_we = cmd.commit && !flush_q;
	assign ram_waddr = target;
	assign ram_wdata = {key_q, new_addr, cnt_q};

	// Request word and the counter, which counts lookups only.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q <= segment_key;
			fill_q <= fill_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.accept) begin
			flush_q <= (command == lsmt_pkg::CMD_FLUSH);
			if (command == lsmt_pkg::CMD_LOOKUP) begin
				cnt_q <= cnt_q + SW'(1);
			end
		end
	end

	// Read index walks the table; the read data is checked in the cycle after its index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			chk_s1 <= 1'b0;
			chk_idx_s1 <= '0;
		end else begin
			chk_s1 <= cmd.scan;
			chk_idx_s1 <= idx_q;
			if (cmd.accept) begin
				idx_q <= '0;
			end else if (cmd.scan && !status.last_read) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// Scan flags: match, first free slot and whether an oldest entry is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			free_q <= 1'b0;
			have_min_q <= 1'b0;
		end else if (cmd.accept) begin
			hit_q <= 1'b0;
			free_q <= 1'b0;
			have_min_q <= 1'b0;
		end else if (chk_s1) begin
			if (rd_valid && rd_key == key_q) begin
				hit_q <= 1'b1;
			end
			if (!rd_valid) begin
				free_q <= 1'b1;
			end
			if (rd_valid) begin
				have_min_q <= 1'b1;
			end
		end
	end

	// Scan payload; only valid entries take part in the compare.
	always_ff @(posedge clk) begin
		if (chk_s1) begin
			if (rd_valid && rd_key == key_q) begin
				hit_idx_q <= chk_idx_s1;
				hit_addr_q <= rd_addr;
			end
			if (!rd_valid && !free_q) begin
				free_idx_q <= chk_idx_s1;
			end
			if (rd_valid && (!have_min_q || rd_stamp < min_q)) begin
				min_q <= rd_stamp;
				min_idx_q <= chk_idx_s1;
				min_key_q <= rd_key;
				min_addr_q <= rd_addr;
			end
		end
	end

	// Valid bits: cleared by a flush, set by a fill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit) begin
			if (flush_q) begin
				valid_q <= '0;
			end else begin
				valid_q[target] <= 1'b1;
			end
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	// Result word; a flush reports all zero.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (flush_q) begin
				hit <= 1'b0;
				slot <= '0;
				mapped_address <= '0;
				evicted <= 1'b0;
				evicted_key <= '0;
				evicted_address <= '0;
			end else begin
				hit <= hit_q;
				slot <= lsmt_pkg::SLOT_W'(target);
				mapped_address <= new_addr;
				evicted <= do_evict;
				evicted_key <= do_evict ? min_key_q : '0;
				evicted_address <= do_evict ? min_addr_q : '0;
			end
		end
	end

	assign done = done_q;

endmodule

[src/lru_segment_mapping_table.sv]
// Fully associative LRU table of ENTRIES slots mapping segment keys to
// addresses. Raise start with a command word while busy is low; the word is
// taken at that edge. A lookup passes the scan, drain and commit states; the
// scan reads one entry per cycle through the entry memory's single read port.
// A flush goes straight to the commit state. In both cases done is registered
// from the commit state. The result is shown for exactly one cycle with done
// high, and the receiver cannot stall it. The result ports hold their value
// until the next result. A new word may be started in the cycle that done is
// high.
module lru_segment_mapping_table #(
	parameter int unsigned ENTRIES = lsmt_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [lsmt_pkg::KEY_W-1:0]    segment_key,
	input  logic [lsmt_pkg::ADDR_W-1:0]   fill_address,
	output logic                          done,
	output logic                          hit,
	output logic [lsmt_pkg::SLOT_W-1:0]   slot,
	output logic [lsmt_pkg::ADDR_W-1:0]   mapped_address,
	output logic                          evicted,
	output logic [lsmt_pkg::KEY_W-1:0]    evicted_key,
	output logic [lsmt_pkg::ADDR_W-1:0]   evicted_address
);

	lsmt_pkg::ctl_cmd_t   cmd;
	lsmt_pkg::dp_status_t status;

	// Sequencer.
	lsmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(command),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Table storage, scan and result registers.
	lsmt_datapath #(
		.ENTRIES(ENTRIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.command        (command),
		.segment_key    (segment_key),
		.fill_address   (fill_address),
		.done           (done),
		.hit            (hit),
		.slot           (slot),
		.mapped_address (mapped_address),
		.evicted        (evicted),
		.evicted_key    (evicted_key),
		.evicted_address(evicted_address)
	);

endmodule

[src/lsmt_checker.sv]
module lsmt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic hit,
	input logic evicted
);

	// A result only appears once the block has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted word always makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not start work");

	// Busy only rises after a start.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	// A hit never evicts.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !evicted)
		else $error("hit reported together with an eviction");

endmodule

bind lru_segment_mapping_table lsmt_checker u_lsmt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.hit    (hit),
	.evicted(evicted)
);
